@@ hdl/fixed_service_queue_backlog_meter_assert.svh @@
// Assertion helpers for the backlog meter; clocked on clk, off during reset.
`ifndef FIXED_SERVICE_QUEUE_BACKLOG_METER_ASSERT_SVH
`define FIXED_SERVICE_QUEUE_BACKLOG_METER_ASSERT_SVH

// Same-cycle implication.
`define FSQBM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FSQBM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/fsqbm_pkg.sv @@
`default_nettype none
package fsqbm_pkg;

	localparam int DEPTH_DEF     = 1024;
	localparam int DATA_W        = 32;
	localparam int OUT_W         = 11;
	localparam int OUT_MAX       = 2047;
	localparam int SERVICE_RESET = 1;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] arrival_stamp;
		logic              new_day;
	} arrival_t;

	typedef struct packed {
		logic [OUT_W-1:0] waiting_count;
		logic [OUT_W-1:0] max_waiting;
		logic             overflow;
	} report_t;

endpackage
`default_nettype wire

@@ hdl/fsqbm_chan_if.sv @@
`default_nettype none
interface fsqbm_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/fixed_service_queue_backlog_meter.sv @@
// Single-server queue backlog meter. Each arrival transaction retires every
// pending completion time at or before its timestamp, schedules its own
// completion one service time after the later of its arrival and the last
// pending completion, and returns one report: items waiting behind the one in
// service, the running maximum since the last new_day, and an overflow flag
// when the ring is full and the item is dropped. Retirements run one after
// another: the ring has one read port and each retirement needs the next head
// entry, read one per cycle. One item is worked on at a time; a finished
// report waits in an output register while the next arrival is taken.
// Completions are kept exactly, 33 + log2(depth) bits wide. The ring needs no
// clearing after reset; the user must write service_time only while no
// transaction is in flight, as the block itself does not enforce it.
`default_nettype none
module fixed_service_queue_backlog_meter #(
	parameter int QUEUE_DEPTH = fsqbm_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [fsqbm_pkg::DATA_W-1:0] cfg_wr_data,
	fsqbm_chan_if.sink                       arrival,
	fsqbm_chan_if.source                     report
);

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int COMP_W = fsqbm_pkg::DATA_W + 1 + $clog2(QUEUE_DEPTH);
	localparam int OUT_W  = fsqbm_pkg::OUT_W;
	localparam int SAT_W  = (IDX_W > OUT_W) ? IDX_W : OUT_W;
	localparam int FULL_WAIT = (QUEUE_DEPTH - 1 > fsqbm_pkg::OUT_MAX) ?
		fsqbm_pkg::OUT_MAX : QUEUE_DEPTH - 1;

	fsqbm_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0]             head_q, head_d, tail_q, tail_d;
	logic [OCC_W-1:0]             occ_q, occ_d;
	logic [OUT_W-1:0]             max_q, max_d;
	logic [fsqbm_pkg::DATA_W-1:0] service_q;
	logic                         report_valid_q;
	fsqbm_pkg::report_t           report_q;

	logic [COMP_W-1:0] last_q, last_d;
	logic [COMP_W-1:0] arr_s1, arr_plus_s1, chain_s1;

	logic [IDX_W-1:0]  rd_addr;
	logic [COMP_W-1:0] rd_data;
	logic              we;
	logic              load_out;

	logic [IDX_W-1:0]  head_nxt, tail_nxt;
	logic              full, retire, out_free;
	logic [COMP_W-1:0] done;
	logic [IDX_W-1:0]  wait_raw;
	logic [SAT_W-1:0]  wait_ext;
	logic [OUT_W-1:0]  wait_sat, max_new;

	fsqbm_ring #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (COMP_W)
	) u_ring (
		.clk     (clk),
		.we      (we),
		.wr_addr (tail_q),
		.wr_data (done),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign head_nxt = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign full     = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign retire   = (occ_q != '0) && (rd_data <= arr_s1);
	assign out_free = !report_valid_q || report.ready;

	// Chain behind the last pending completion when one is left.
	assign done = ((occ_q != '0) && (chain_s1 > arr_plus_s1)) ? chain_s1 : arr_plus_s1;

	assign wait_raw = full ? IDX_W'(QUEUE_DEPTH - 1) : occ_q[IDX_W-1:0];
	assign wait_ext = SAT_W'(wait_raw);
	assign wait_sat = (wait_ext > SAT_W'(fsqbm_pkg::OUT_MAX)) ?
		OUT_W'(fsqbm_pkg::OUT_MAX) : wait_ext[OUT_W-1:0];
	assign max_new  = (wait_sat > max_q) ? wait_sat : max_q;

	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		tail_d        = tail_q;
		occ_d         = occ_q;
		max_d         = max_q;
		last_d        = last_q;
		rd_addr       = head_q;
		we            = 1'b0;
		load_out      = 1'b0;
		arrival.ready = (state_q == fsqbm_pkg::ST_IDLE);
		case (state_q)
			fsqbm_pkg::ST_IDLE: begin
				if (arrival.valid) begin
					state_d = fsqbm_pkg::ST_POP;
					if (arrival.data.new_day) begin
						head_d  = '0;
						tail_d  = '0;
						occ_d   = '0;
						max_d   = '0;
						rd_addr = '0;
					end
				end
			end
			fsqbm_pkg::ST_POP: begin
				if (retire) begin
					// Advance the head and fetch the next entry.
					head_d  = head_nxt;
					occ_d   = occ_q - 1'b1;
					rd_addr = head_nxt;
				end else if (out_free) begin
					if (!full) begin
						we     = 1'b1;
						tail_d = tail_nxt;
						occ_d  = occ_q + 1'b1;
						last_d = done;
					end
					max_d    = max_new;
					load_out = 1'b1;
					state_d  = fsqbm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fsqbm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= fsqbm_pkg::ST_IDLE;
			head_q         <= '0;
			tail_q         <= '0;
			occ_q          <= '0;
			max_q          <= '0;
			service_q      <= fsqbm_pkg::DATA_W'(fsqbm_pkg::SERVICE_RESET);
			report_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			max_q   <= max_d;
			if (cfg_wr_en) begin
				service_q <= cfg_wr_data;
			end
			if (load_out) begin
				report_valid_q <= 1'b1;
			end else if (report.ready) begin
				report_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_q <= last_d;
		if (arrival.valid && arrival.ready) begin
			arr_s1      <= COMP_W'(arrival.data.arrival_stamp);
			arr_plus_s1 <= COMP_W'(arrival.data.arrival_stamp) + COMP_W'(service_q);
			chain_s1    <= last_q + COMP_W'(service_q);
		end
		if (load_out) begin
			report_q.waiting_count <= wait_sat;
			report_q.max_waiting   <= max_new;
			report_q.overflow      <= full;
		end
	end

	assign report.valid = report_valid_q;
	assign report.data  = report_q;

`include "fixed_service_queue_backlog_meter_assert.svh"

	`FSQBM_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= OCC_W'(QUEUE_DEPTH), "occupancy above depth")
	`FSQBM_ASSERT_IMP(a_max_covers, report.valid,
		report.data.max_waiting >= report.data.waiting_count, "maximum below waiting count")
	`FSQBM_ASSERT_IMP(a_ovf_count, report.valid && report.data.overflow,
		report.data.waiting_count == OUT_W'(FULL_WAIT), "overflow report with wrong count")
	`FSQBM_ASSERT_NXT(a_accept_pop, arrival.valid && arrival.ready,
		state_q == fsqbm_pkg::ST_POP, "accepted transaction not in retirement")

endmodule
`default_nettype wire

@@ hdl/fsqbm_ring.sv @@
`default_nettype none
module fsqbm_ring #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire
